// ===== rtl/iouc_pkg.sv =====
`default_nettype none

package iouc_pkg;

    // Geometry and fixed-point format
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int CRD_W  = COORD_BITS;          // box left / top
    localparam int SIZE_W = COORD_BITS - 1;      // box width / height
    localparam int EDGE_W = COORD_BITS + 1;      // left + width, never wraps
    localparam int AREA_W = 2 * SIZE_W;          // product of two sizes
    localparam int UNI_W  = AREA_W + 1;          // sum of two areas
    localparam int REM_W  = UNI_W + 1;           // divider remainder after shift
    localparam int IOU_W  = FRAC_BITS + 1;       // Q1.FRAC, value 1.0 included
    localparam int THR_W  = FRAC_BITS + 1;
    localparam int COST_W = FRAC_BITS + 8;       // Q8.FRAC
    localparam int CFG_W  = COST_W;
    localparam int IDX_W  = 2;

    // Divider produces one quotient bit per stage
    localparam int DIV_STEPS = FRAC_BITS + 1;

    localparam logic [IOU_W-1:0]  IOU_ONE          = IOU_W'(1) << FRAC_BITS;
    localparam logic [THR_W-1:0]  THR_RESET        = '0;
    localparam logic [COST_W-1:0] MAX_COST_RESET   = COST_W'(65536);
    localparam logic [COST_W-1:0] PASS_LIMIT_RESET = COST_W'(52429);

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_IOU_THRESHOLD = 2'd0,
        REG_MAX_COST      = 2'd1,
        REG_PASS_LIMIT    = 2'd2
    } reg_idx_t;

    // How a cell resolves
    typedef enum logic [1:0] {
        MODE_BOTH_PAD = 2'd0,
        MODE_ONE_PAD  = 2'd1,
        MODE_DISJOINT = 2'd2,
        MODE_REAL     = 2'd3
    } mode_t;

    // Sideband that travels beside the divider data
    typedef struct packed {
        mode_t mode;
    } side_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] row_x;
        logic signed [CRD_W-1:0] row_y;
        logic [SIZE_W-1:0]       row_w;
        logic [SIZE_W-1:0]       row_h;
        logic signed [CRD_W-1:0] col_x;
        logic signed [CRD_W-1:0] col_y;
        logic [SIZE_W-1:0]       col_w;
        logic [SIZE_W-1:0]       col_h;
        logic                    row_real;
        logic                    col_real;
    } in_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [IOU_W-1:0]  iou_value;
        logic              gated;
    } out_t;

endpackage

`default_nettype wire

// ===== rtl/iouc_div.sv =====
`default_nettype none

// Pipelined restoring divider: quo = floor(num * 2^FRAC_BITS / den), num <= den.
// One quotient bit per stage, DIV_STEPS stages.
module iouc_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire iouc_pkg::side_t            in_side,
    input  wire logic [iouc_pkg::AREA_W-1:0] num,
    input  wire logic [iouc_pkg::UNI_W-1:0]  den,
    output logic                            out_valid,
    output iouc_pkg::side_t                 out_side,
    output logic [iouc_pkg::IOU_W-1:0]      quo
);
    import iouc_pkg::*;

    logic [DIV_STEPS-1:0] vld_reg;
    side_t                side_reg [DIV_STEPS];
    logic [REM_W-1:0]     rem_reg  [DIV_STEPS];
    logic [REM_W-1:0]     rem_next [DIV_STEPS];
    logic [REM_W-1:0]     rem_in   [DIV_STEPS];
    logic [UNI_W-1:0]     den_reg  [DIV_STEPS];
    logic [UNI_W-1:0]     den_in   [DIV_STEPS];
    logic [IOU_W-1:0]     q_reg    [DIV_STEPS];
    logic [IOU_W-1:0]     q_next   [DIV_STEPS];
    logic [IOU_W-1:0]     q_in     [DIV_STEPS];
    logic [DIV_STEPS-1:0] ge;

    // One compare-subtract per stage; first stage takes the integer bit
    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = REM_W'(num);
                den_in[k] = den;
                q_in[k]   = '0;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1] << 1;
                den_in[k] = den_reg[k-1];
                q_in[k]   = q_reg[k-1];
            end
            ge[k]       = rem_in[k] >= REM_W'(den_in[k]);
            rem_next[k] = ge[k] ? rem_in[k] - REM_W'(den_in[k]) : rem_in[k];
            q_next[k]   = {q_in[k][IOU_W-2:0], ge[k]};
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    // Stage data
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            rem_reg[k] <= rem_next[k];
            q_reg[k]   <= q_next[k];
            den_reg[k] <= den_in[k];
            side_reg[k] <= (k == 0) ? in_side : side_reg[k == 0 ? 0 : k-1];
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];
    assign quo       = q_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/iou_assignment_cost_cell_core.sv =====
// IoU cost cell. One cell of the assignment cost matrix enters per clock
// whenever start is high; busy is always low, the pipeline never stalls.
// Every item gives one result, shown for one cycle with done high, after it
// has passed 4 geometry and area stages, 17 divider stages at one quotient
// bit each and one cost stage; results leave in input order and must be
// taken when shown. Configuration is sampled in the last stage, so write it
// only while no item is in flight.
`default_nettype none

module iou_assignment_cost_cell_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire iouc_pkg::in_t               request,
    input  wire logic                        cfg_we,
    input  wire logic [iouc_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [iouc_pkg::CFG_W-1:0]  cfg_data,
    output logic                             done,
    output iouc_pkg::out_t                   result
);
    import iouc_pkg::*;

    localparam int LATENCY = DIV_STEPS + 5;

    logic accept;

    // Configuration registers
    logic [THR_W-1:0]  iou_threshold_reg;
    logic [COST_W-1:0] max_cost_reg;
    logic [COST_W-1:0] pass_limit_reg;

    // Stage 1: intersection edges
    logic                     s1_vld_reg;
    mode_t                    s1_mode_reg;
    logic signed [EDGE_W-1:0] s1_il_reg, s1_ir_reg, s1_it_reg, s1_ib_reg;
    logic [SIZE_W-1:0]        s1_rw_reg, s1_rh_reg, s1_cw_reg, s1_ch_reg;
    logic signed [EDGE_W-1:0] s1_il_next, s1_ir_next, s1_it_next, s1_ib_next;
    mode_t                    s1_mode_next;
    logic signed [EDGE_W-1:0] rx, ry, cx, cy, rr, rb, cr, cb;

    // Stage 2: extents and disjoint test
    logic                     s2_vld_reg;
    mode_t                    s2_mode_reg;
    logic [SIZE_W-1:0]        s2_dx_reg, s2_dy_reg;
    logic [SIZE_W-1:0]        s2_rw_reg, s2_rh_reg, s2_cw_reg, s2_ch_reg;
    logic signed [EDGE_W-1:0] dx_full, dy_full;
    mode_t                    s2_mode_next;

    // Stage 3: areas
    logic              s3_vld_reg;
    mode_t             s3_mode_reg;
    logic [AREA_W-1:0] s3_inter_reg, s3_ar_reg, s3_ac_reg;

    // Stage 4: union
    logic              s4_vld_reg;
    side_t             s4_side_reg;
    logic [AREA_W-1:0] s4_inter_reg;
    logic [UNI_W-1:0]  s4_den_reg;
    logic [UNI_W-1:0]  uni_next;

    // Divider outputs
    logic             dv_vld;
    side_t            dv_side;
    logic [IOU_W-1:0] dv_quo;

    // Output stage
    logic  done_reg;
    out_t  result_reg;
    out_t  result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iou_threshold_reg <= THR_RESET;
            max_cost_reg      <= MAX_COST_RESET;
            pass_limit_reg    <= PASS_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IOU_THRESHOLD: iou_threshold_reg <= cfg_data[THR_W-1:0];
                REG_MAX_COST:      max_cost_reg      <= cfg_data[COST_W-1:0];
                REG_PASS_LIMIT:    pass_limit_reg    <= cfg_data[COST_W-1:0];
                default:           ;
            endcase
        end
    end

    // Stage 1 logic: edges at full precision
    always_comb
    begin
        rx = {request.row_x[CRD_W-1], request.row_x};
        ry = {request.row_y[CRD_W-1], request.row_y};
        cx = {request.col_x[CRD_W-1], request.col_x};
        cy = {request.col_y[CRD_W-1], request.col_y};
        rr = rx + $signed({2'b00, request.row_w});
        rb = ry + $signed({2'b00, request.row_h});
        cr = cx + $signed({2'b00, request.col_w});
        cb = cy + $signed({2'b00, request.col_h});
        s1_il_next = (rx > cx) ? rx : cx;
        s1_ir_next = (rr < cr) ? rr : cr;
        s1_it_next = (ry > cy) ? ry : cy;
        s1_ib_next = (rb < cb) ? rb : cb;
        if (request.row_real && request.col_real)
        begin
            s1_mode_next = MODE_REAL;
        end
        else if (request.row_real || request.col_real)
        begin
            s1_mode_next = MODE_ONE_PAD;
        end
        else
        begin
            s1_mode_next = MODE_BOTH_PAD;
        end
    end

    // Stage 2 logic: overlap extents; extents fit in a size when not disjoint
    always_comb
    begin
        dx_full = s1_ir_reg - s1_il_reg;
        dy_full = s1_ib_reg - s1_it_reg;
        s2_mode_next = s1_mode_reg;
        if (s1_mode_reg == MODE_REAL &&
            (s1_il_reg > s1_ir_reg || s1_it_reg > s1_ib_reg))
        begin
            s2_mode_next = MODE_DISJOINT;
        end
    end

    // Stage 4 logic: union; a zero union only comes with zero intersection
    assign uni_next = UNI_W'(s3_ar_reg) + UNI_W'(s3_ac_reg) - UNI_W'(s3_inter_reg);

    // Front pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // Front pipeline data
    always_ff @(posedge clk)
    begin
        s1_mode_reg <= s1_mode_next;
        s1_il_reg   <= s1_il_next;
        s1_ir_reg   <= s1_ir_next;
        s1_it_reg   <= s1_it_next;
        s1_ib_reg   <= s1_ib_next;
        s1_rw_reg   <= request.row_w;
        s1_rh_reg   <= request.row_h;
        s1_cw_reg   <= request.col_w;
        s1_ch_reg   <= request.col_h;

        s2_mode_reg <= s2_mode_next;
        s2_dx_reg   <= dx_full[SIZE_W-1:0];
        s2_dy_reg   <= dy_full[SIZE_W-1:0];
        s2_rw_reg   <= s1_rw_reg;
        s2_rh_reg   <= s1_rh_reg;
        s2_cw_reg   <= s1_cw_reg;
        s2_ch_reg   <= s1_ch_reg;

        s3_mode_reg  <= s2_mode_reg;
        s3_inter_reg <= AREA_W'(s2_dx_reg) * AREA_W'(s2_dy_reg);
        s3_ar_reg    <= AREA_W'(s2_rw_reg) * AREA_W'(s2_rh_reg);
        s3_ac_reg    <= AREA_W'(s2_cw_reg) * AREA_W'(s2_ch_reg);

        s4_side_reg.mode <= s3_mode_reg;
        s4_inter_reg     <= s3_inter_reg;
        s4_den_reg       <= (uni_next == '0) ? UNI_W'(1) : uni_next;
    end

    iouc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_vld_reg),
        .in_side   (s4_side_reg),
        .num       (s4_inter_reg),
        .den       (s4_den_reg),
        .out_valid (dv_vld),
        .out_side  (dv_side),
        .quo       (dv_quo)
    );

    // Cost selection
    always_comb
    begin
        result_next = '0;
        case (dv_side.mode)
            MODE_BOTH_PAD:
            begin
                result_next = '0;
            end
            MODE_ONE_PAD:
            begin
                result_next.cost = pass_limit_reg >> 1;
            end
            MODE_DISJOINT:
            begin
                result_next.cost  = max_cost_reg;
                result_next.gated = 1'b1;
            end
            MODE_REAL:
            begin
                result_next.iou_value = dv_quo;
                if (dv_quo < iou_threshold_reg)
                begin
                    result_next.cost  = max_cost_reg;
                    result_next.gated = 1'b1;
                end
                else if (max_cost_reg > COST_W'(dv_quo))
                begin
                    result_next.cost = max_cost_reg - COST_W'(dv_quo);
                end
                else
                begin
                    result_next.cost = '0;
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    // Output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Fixed latency: every accepted item comes out, nothing stalls
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("item did not leave after the pipeline latency");

    // IoU never exceeds one
    a_iou_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.iou_value <= IOU_ONE)
        else $error("IoU above one");

    // Gated cells carry the maximum cost
    a_gated_cost: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.gated |-> result.cost == max_cost_reg)
        else $error("gated cell without maximum cost");

    // Gating only happens for zero or sub-threshold IoU
    a_gated_iou: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.gated |->
            (result.iou_value == '0) || (result.iou_value < iou_threshold_reg))
        else $error("cell gated above threshold");

endmodule

`default_nettype wire

// ===== bench/tb_iou_assignment_cost_cell_core.sv =====
`timescale 1ns / 1ps

module tb_iou_assignment_cost_cell_core;
    import iouc_pkg::*;

    localparam int PIPE_LAT     = 22;
    localparam int ITEMS_PHASE  = 67;
    localparam int NUM_PHASES   = 6;

    // Expected cell costs, worked out from the box geometry and the
    // current register copy; results are matched in arrival order.
    class iou_cost_checker;
        logic [THR_W-1:0]  iou_threshold;
        logic [COST_W-1:0] max_cost;
        logic [COST_W-1:0] pass_limit;
        out_t              expected_costs[$];
        int                errors;

        function new();
            iou_threshold = THR_RESET;
            max_cost      = MAX_COST_RESET;
            pass_limit    = PASS_LIMIT_RESET;
            errors        = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_IOU_THRESHOLD: iou_threshold = v[THR_W-1:0];
                REG_MAX_COST:      max_cost      = v[COST_W-1:0];
                REG_PASS_LIMIT:    pass_limit    = v[COST_W-1:0];
                default: ;
            endcase
        endfunction

        function out_t predict_cell_cost(in_t c);
            out_t   r;
            longint rx, ry, rw, rh, cx, cy, cw, ch;
            longint il, ir, it, ib, inter, uni, iou, mc;
            r = '0;
            if (!c.row_real && !c.col_real)
                r.cost = '0;
            else if (!c.row_real || !c.col_real)
                r.cost = pass_limit >> 1;
            else
            begin
                rx = longint'($signed(c.row_x));
                ry = longint'($signed(c.row_y));
                cx = longint'($signed(c.col_x));
                cy = longint'($signed(c.col_y));
                rw = longint'(c.row_w);
                rh = longint'(c.row_h);
                cw = longint'(c.col_w);
                ch = longint'(c.col_h);
                // intersection edges at full precision
                il = (rx > cx) ? rx : cx;
                ir = (rx + rw < cx + cw) ? rx + rw : cx + cw;
                it = (ry > cy) ? ry : cy;
                ib = (ry + rh < cy + ch) ? ry + rh : cy + ch;
                if (il > ir || it > ib)
                begin
                    r.cost  = max_cost;
                    r.gated = 1'b1;
                end
                else
                begin
                    inter = (ir - il) * (ib - it);
                    uni   = rw * rh + cw * ch;
                    uni   = (uni >= inter) ? uni - inter : 0;
                    iou   = 0;
                    // zero union reads as IoU 0
                    if (uni != 0 && inter <= uni)
                        iou = (inter << FRAC_BITS) / uni;
                    else if (uni != 0)
                        iou = longint'(1) << FRAC_BITS;
                    r.iou_value = iou[IOU_W-1:0];
                    mc = longint'(max_cost);
                    if (iou < longint'(iou_threshold))
                    begin
                        r.cost  = max_cost;
                        r.gated = 1'b1;
                    end
                    else
                        r.cost = (mc > iou) ? COST_W'(mc - iou) : '0;
                end
            end
            return r;
        endfunction

        function void note_cell(in_t c);
            expected_costs = {expected_costs, predict_cell_cost(c)};
        endfunction

        function void check_cost(out_t got);
            out_t exp_r;
            if (expected_costs.size() == 0)
            begin
                $display("%0t: result with no item pending: cost %0d iou %0d gated %0d",
                         $time, got.cost, got.iou_value, got.gated);
                errors++;
                return;
            end
            exp_r = expected_costs.pop_front();
            if (got.cost !== exp_r.cost)
            begin
                $display("%0t: cost mismatch: expected %0d, got %0d",
                         $time, exp_r.cost, got.cost);
                errors++;
            end
            if (got.iou_value !== exp_r.iou_value)
            begin
                $display("%0t: iou_value mismatch: expected %0d, got %0d",
                         $time, exp_r.iou_value, got.iou_value);
                errors++;
            end
            if (got.gated !== exp_r.gated)
            begin
                $display("%0t: gated mismatch: expected %0b, got %0b",
                         $time, exp_r.gated, got.gated);
                errors++;
            end
        endfunction

        function int pending();
            return expected_costs.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    in_t               request;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              done;
    out_t              result;

    iou_cost_checker cell_costs = new();

    iou_assignment_cost_cell_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case results never show up
    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    // results are valid for one cycle only
    always @(posedge clk)
    begin
        if (rst_n && done)
            cell_costs.check_cost(result);
    end

    // write all three registers on back-to-back edges
    task automatic write_cfg(int unsigned thr, int unsigned mc, int unsigned lim);
        reg_idx_t    idx[3];
        int unsigned val[3];
        idx = '{REG_IOU_THRESHOLD, REG_MAX_COST, REG_PASS_LIMIT};
        val = '{thr, mc, lim};
        cfg_we <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= CFG_W'(val[i]);
            @(posedge clk);
            cell_costs.write_reg(idx[i], CFG_W'(val[i]));
        end
        cfg_we <= 1'b0;
    endtask

    // start stays high across back-to-back items
    task automatic send_cell(in_t c);
        request <= c;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        cell_costs.note_cell(c);
    endtask

    task automatic maybe_idle(int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < pct);
        end
    endtask

    // hold off until every expected cost has come back
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge clk);
        while (cell_costs.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    function automatic in_t make_cell(int rx, int ry, int rw, int rh,
                                      int cx, int cy, int cw, int ch,
                                      bit rr, bit cr);
        in_t c;
        c.row_x    = CRD_W'(rx);
        c.row_y    = CRD_W'(ry);
        c.row_w    = SIZE_W'(rw);
        c.row_h    = SIZE_W'(rh);
        c.col_x    = CRD_W'(cx);
        c.col_y    = CRD_W'(cy);
        c.col_w    = SIZE_W'(cw);
        c.col_h    = SIZE_W'(ch);
        c.row_real = rr;
        c.col_real = cr;
        return c;
    endfunction

    function automatic in_t random_cell();
        in_t c;
        int  kind, rx, ry, rw, rh;
        kind = $urandom_range(99);
        rx = int'($urandom_range(2000)) - 1000;
        ry = int'($urandom_range(2000)) - 1000;
        rw = $urandom_range(300, 1);
        rh = $urandom_range(300, 1);
        if (kind < 60)
        begin
            // nearby track/detection pair, jittered, overlapping or not
            c = make_cell(rx, ry, rw, rh,
                          rx + int'($urandom_range(2 * rw)) - rw,
                          ry + int'($urandom_range(2 * rh)) - rh,
                          $urandom_range(rw + rw / 2, rw / 2),
                          $urandom_range(rh + rh / 2, rh / 2), 1'b1, 1'b1);
        end
        else if (kind < 68)
        begin
            // same box both sides, sometimes degenerate
            if ($urandom_range(3) == 0)
                rw = 0;
            c = make_cell(rx, ry, rw, rh, rx, ry, rw, rh, 1'b1, 1'b1);
        end
        else if (kind < 76)
        begin
            // adjacent: touching or one pixel apart
            c = make_cell(rx, ry, rw, rh, rx + rw + int'($urandom_range(1)), ry,
                          $urandom_range(300), rh, 1'b1, 1'b1);
        end
        else if (kind < 92)
        begin
            // raw bits, flags included
            c = in_t'($bits(in_t)'({$urandom, $urandom, $urandom, $urandom}));
        end
        else
        begin
            c = in_t'($bits(in_t)'({$urandom, $urandom, $urandom, $urandom}));
            c.row_real = $urandom_range(1);
            c.col_real = c.row_real ? 1'b0 : $urandom_range(1);
        end
        return c;
    endfunction

    initial
    begin
        int idle_pct;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        request   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_IOU_THRESHOLD;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cells at reset configuration
        send_cell(make_cell(0, 0, 10, 10, 0, 0, 10, 10, 1'b0, 1'b0));
        send_cell(make_cell(0, 0, 10, 10, 0, 0, 10, 10, 1'b0, 1'b1));
        send_cell(make_cell(0, 0, 10, 10, 0, 0, 10, 10, 1'b1, 1'b0));
        send_cell(make_cell(10, 10, 20, 20, 10, 10, 20, 20, 1'b1, 1'b1));
        // touching edges, then one pixel apart each way
        send_cell(make_cell(0, 0, 10, 10, 10, 0, 10, 10, 1'b1, 1'b1));
        send_cell(make_cell(0, 0, 10, 10, 11, 0, 10, 10, 1'b1, 1'b1));
        send_cell(make_cell(0, 0, 10, 10, 0, 11, 10, 10, 1'b1, 1'b1));
        // zero union
        send_cell(make_cell(5, 5, 0, 0, 5, 5, 0, 0, 1'b1, 1'b1));
        // coordinate and size extremes
        send_cell(make_cell(-32768, -32768, 32767, 32767,
                            -32768, -32768, 32767, 32767, 1'b1, 1'b1));
        send_cell(make_cell(32767, 32767, 32767, 32767,
                            32767, 32767, 32767, 32767, 1'b1, 1'b1));
        send_cell(make_cell(-32768, -32768, 32767, 32767,
                            32767, 32767, 32767, 32767, 1'b1, 1'b1));
        send_cell(make_cell(-32768, 0, 32767, 100, -1, 50, 32767, 100, 1'b1, 1'b1));
        // nested, partial, zero width inside
        send_cell(make_cell(0, 0, 100, 100, 25, 25, 50, 50, 1'b1, 1'b1));
        send_cell(make_cell(0, 0, 100, 100, 50, 30, 100, 100, 1'b1, 1'b1));
        send_cell(make_cell(0, 0, 10, 10, 5, 5, 0, 10, 1'b1, 1'b1));
        send_cell(make_cell(-32768, 32767, 0, 32767, 32767, -32768, 32767, 0,
                            1'b0, 1'b1));
        drain_pipe();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1: write_cfg(32768, 24'hFFFFFF, 24'hFFFFFF);
                2: write_cfg(65536, 0, 0);
                3: write_cfg($urandom_range(65536), $urandom & 24'hFFFFFF,
                             $urandom & 24'hFFFFFF);
                4: write_cfg(0, 30000, 1);
                5: write_cfg($urandom_range(20000), 65536 + $urandom_range(1000), 52429);
                default: ;
            endcase
            idle_pct = (ph < 2) ? 15 : (ph < 4) ? 71 : 0;
            for (int n = 0; n < ITEMS_PHASE; n++)
            begin
                if (ph == 2 && n == ITEMS_PHASE / 2)
                    drain_pipe();
                maybe_idle(idle_pct);
                send_cell(random_cell());
            end
            drain_pipe();
        end

        if (cell_costs.pending() != 0)
            $display("%0t: %0d expected results never arrived",
                     $time, cell_costs.pending());
        if (cell_costs.errors == 0 && cell_costs.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/iouc_pkg.sv
rtl/iouc_div.sv
rtl/iou_assignment_cost_cell_core.sv
bench/tb_iou_assignment_cost_cell_core.sv
